@@ hw/rtl/wma_pkg.sv @@
package wma_pkg;

   localparam int DEPTH_DEFAULT        = 16;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int WINDOW_WIDTH         = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE,
      ST_FINISH
   } wma_state_type;

endpackage

@@ hw/rtl/wma_div.sv @@
module wma_div #(
   parameter int SUM_W = 21,
   parameter int WIN_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [WIN_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(SUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] num_ff, num_in;
   logic [WIN_W-1:0] rem_ff, rem_in;
   logic [WIN_W-1:0] den_ff, den_in;
   logic [WIN_W:0]   trial;
   logic [WIN_W:0]   diff;
   logic             ge;

   // one quotient bit a cycle, the dividend shifts out as the quotient shifts in
   always_comb begin
      trial   = {rem_ff, num_ff[SUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W - 1);
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[SUM_W-2:0], ge};
         rem_in = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

@@ hw/rtl/windowed_moving_average.sv @@
// a request steps through update, divider start, divide and finish before rsp_valid is set;
//    one request is in work at a time: req_ready stays low until its result is registered;
//    the radix-2 divider produces one quotient bit a cycle from the running sum and the fill count
// reset: synchronous, clears sum, count, index and any pending result; window back to DEPTH
// a window write restarts averaging; the ring is not swept, stale entries are never read
module windowed_moving_average #(
   parameter int DEPTH        = wma_pkg::DEPTH_DEFAULT,
   parameter int SAMPLE_WIDTH = wma_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_reading,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_average,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wma_pkg::WINDOW_WIDTH-1:0]     csr_window_size
);

   localparam int WIN_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W = SAMPLE_WIDTH + WIN_W;
   localparam int CMP_W = (WIN_W > wma_pkg::WINDOW_WIDTH) ? WIN_W : wma_pkg::WINDOW_WIDTH;

   wma_pkg::wma_state_type state_ff, state_in;

   logic [WIN_W-1:0]               win_ff, win_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [WIN_W-1:0]               count_ff, count_in;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] avg_ff, avg_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic                           neg_ff, neg_in;
   logic signed [SAMPLE_WIDTH-1:0] old_ff;

   logic signed [SAMPLE_WIDTH-1:0] ring_mem [DEPTH];

   logic                           req_take;
   logic                           csr_take;
   logic                           full;
   logic                           mem_we;
   logic [CMP_W-1:0]               csr_ext;
   logic [WIN_W:0]                 idx_next;
   logic [SUM_W-1:0]               sum_mag;
   logic                           div_start;
   logic                           div_done;
   logic [SUM_W-1:0]               div_quot;
   logic [SAMPLE_WIDTH-1:0]        quot_low;

   // window writes only land between requests
   assign csr_ready = (state_ff == wma_pkg::ST_IDLE);
   assign req_ready = (state_ff == wma_pkg::ST_IDLE) && !csr_valid;
   assign req_take  = req_valid && req_ready;
   assign csr_take  = csr_valid && csr_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = avg_ff;

   assign full     = count_ff >= win_ff;
   assign csr_ext  = CMP_W'(csr_window_size);
   assign idx_next = (WIN_W + 1)'(idx_ff) + 1'b1;
   assign sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign quot_low = div_quot[SAMPLE_WIDTH-1:0];

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      avg_in       = avg_ff;
      sample_in    = sample_ff;
      neg_in       = neg_ff;
      mem_we       = 1'b0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         wma_pkg::ST_IDLE: begin
            if (csr_take) begin
               if (csr_ext == '0 || csr_ext > CMP_W'(DEPTH)) begin
                  win_in = WIN_W'(DEPTH);
               end else begin
                  win_in = WIN_W'(csr_ext);
               end
               idx_in   = '0;
               count_in = '0;
               sum_in   = '0;
            end else if (req_take) begin
               // ring read at idx_ff lands in old_ff for the next cycle
               sample_in = req_reading;
               state_in  = wma_pkg::ST_UPDATE;
            end
         end
         wma_pkg::ST_UPDATE: begin
            mem_we = 1'b1;
            if (full) begin
               sum_in = sum_ff + SUM_W'(sample_ff) - SUM_W'(old_ff);
            end else begin
               sum_in   = sum_ff + SUM_W'(sample_ff);
               count_in = count_ff + 1'b1;
            end
            if (idx_next >= (WIN_W + 1)'(win_ff)) begin
               idx_in = '0;
            end else begin
               idx_in = idx_next[IDX_W-1:0];
            end
            state_in = wma_pkg::ST_START;
         end
         wma_pkg::ST_START: begin
            div_start = 1'b1;
            neg_in    = sum_ff[SUM_W-1];
            state_in  = wma_pkg::ST_DIVIDE;
         end
         wma_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = wma_pkg::ST_FINISH;
            end
         end
         wma_pkg::ST_FINISH: begin
            // hold the quotient until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               avg_in       = neg_ff ? -quot_low : quot_low;
               rsp_valid_in = 1'b1;
               state_in     = wma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wma_pkg::ST_IDLE;
         win_ff       <= WIN_W'(DEPTH);
         idx_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff    <= avg_in;
      sample_ff <= sample_in;
      neg_ff    <= neg_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[idx_ff] <= sample_ff;
      end
      old_ff <= ring_mem[idx_ff];
   end

   wma_div #(
      .SUM_W (SUM_W),
      .WIN_W (WIN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

endmodule

@@ hw/rtl/wma_check.sv @@
module wma_check #(
   parameter int SAMPLE_WIDTH = wma_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [SAMPLE_WIDTH-1:0]       rsp_average,
   input logic                          csr_valid,
   input logic                          csr_ready
);

   // a stalled result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average))
      else $error("result changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // the block stays busy until the result is registered, so req_ready stays low after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request taken while the previous one is in work");

   // a window write never lands together with a request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !(csr_valid && csr_ready))
      else $error("request and window write taken together");

endmodule

bind windowed_moving_average wma_check #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_wma_check (.*);
